/* hw/rtl/svsm_pkg.sv */
// Shared types and codes for the sparse vector scaled merge add block.
`default_nettype none

package svsm_pkg;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_MERGED = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_ORDER = 2'd2;

  localparam logic REG_SCALE_SELF  = 1'b0;
  localparam logic REG_SCALE_OTHER = 1'b1;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Item passed from the front to the merge engine.
  typedef struct packed {
    logic       is_run;
    logic [1:0] status;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/svsm_front.sv */
// Front end: accepts items, checks loads, writes the stores and queues commands.
`default_nettype none

module svsm_front #(
  parameter int DEPTH = 32,
  parameter int IW    = 32,
  parameter int CW    = 6,
  parameter int AW    = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_cmd,
  input  wire logic [31:0]          in_entry_index,
  input  wire logic signed [31:0]   in_entry_value,
  input  wire logic                 q_full,
  output logic                      push,
  output svsm_pkg::cmd_t            push_cmd,
  output logic                      wr_a,
  output logic                      wr_b,
  output logic [AW-1:0]             wr_addr,
  output logic [IW-1:0]             wr_idx,
  output logic signed [31:0]        wr_val,
  output logic [CW-1:0]             cnt_a,
  output logic [CW-1:0]             cnt_b,
  input  wire logic                 run_done
);

  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [IW-1:0] last_a_r, last_a_nxt;
  logic [IW-1:0] last_b_r, last_b_nxt;
  logic          run_pend_r, run_pend_nxt;
  logic          acc;
  logic          is_load;
  logic          sel_b;
  logic [CW-1:0] cnt_sel;
  logic [IW-1:0] last_sel;
  logic [IW-1:0] idx;
  logic [1:0]    status;

  assign busy    = q_full | run_pend_r;
  assign acc     = start & ~busy;
  assign cnt_a   = cnt_a_r;
  assign cnt_b   = cnt_b_r;
  assign idx     = in_entry_index[IW-1:0];
  assign is_load = (in_cmd == svsm_pkg::CMD_LOAD_A) || (in_cmd == svsm_pkg::CMD_LOAD_B);
  assign sel_b   = (in_cmd == svsm_pkg::CMD_LOAD_B);
  assign cnt_sel  = sel_b ? cnt_b_r : cnt_a_r;
  assign last_sel = sel_b ? last_b_r : last_a_r;
  assign wr_addr  = cnt_sel[AW-1:0];
  assign wr_idx   = idx;
  assign wr_val   = in_entry_value;

  always_comb begin
    if (cnt_sel == CW'(DEPTH)) begin
      status = svsm_pkg::STAT_FULL;
    end else if ((cnt_sel != '0) && (idx <= last_sel)) begin
      status = svsm_pkg::STAT_ORDER;
    end else begin
      status = svsm_pkg::STAT_OK;
    end
  end

  always_comb begin
    push         = 1'b0;
    push_cmd     = '{is_run: 1'b0, status: status};
    wr_a         = 1'b0;
    wr_b         = 1'b0;
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    last_a_nxt   = last_a_r;
    last_b_nxt   = last_b_r;
    run_pend_nxt = run_pend_r;
    if (run_done) begin
      cnt_a_nxt    = '0;
      cnt_b_nxt    = '0;
      run_pend_nxt = 1'b0;
    end
    if (acc && is_load) begin
      push = 1'b1;
      if (status == svsm_pkg::STAT_OK) begin
        if (sel_b) begin
          wr_b       = 1'b1;
          cnt_b_nxt  = cnt_b_r + CW'(1);
          last_b_nxt = idx;
        end else begin
          wr_a       = 1'b1;
          cnt_a_nxt  = cnt_a_r + CW'(1);
          last_a_nxt = idx;
        end
      end
    end else if (acc && (in_cmd == svsm_pkg::CMD_RUN)) begin
      push         = 1'b1;
      push_cmd     = '{is_run: 1'b1, status: svsm_pkg::STAT_OK};
      run_pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      run_pend_r <= 1'b0;
    end else begin
      cnt_a_r    <= cnt_a_nxt;
      cnt_b_r    <= cnt_b_nxt;
      run_pend_r <= run_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_a_r <= last_a_nxt;
    last_b_r <= last_b_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/svsm_queue.sv */
// Two-entry command queue between the front end and the merge engine.
`default_nettype none

module svsm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  svsm_pkg::cmd_t      push_cmd,
  output logic                full,
  output logic                valid,
  input  wire logic           pop,
  output svsm_pkg::cmd_t      head
);

  svsm_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (fill_r == 2'd2);
  assign valid   = (fill_r != 2'd0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/svsm_merge.sv */
// Merge engine: holds both stores, walks them in index order and drives results.
`default_nettype none

module svsm_merge #(
  parameter int DEPTH     = 32,
  parameter int IW        = 32,
  parameter int CW        = 6,
  parameter int AW        = 5,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  svsm_pkg::cmd_t            q_cmd,
  output logic                      pop,
  input  wire logic                 wr_a,
  input  wire logic                 wr_b,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [IW-1:0]        wr_idx,
  input  wire logic signed [31:0]   wr_val,
  input  wire logic [CW-1:0]        cnt_a,
  input  wire logic [CW-1:0]        cnt_b,
  input  wire logic signed [31:0]   scale_self,
  input  wire logic signed [31:0]   scale_other,
  output logic                      run_done,
  output logic                      out_valid,
  output logic [1:0]                out_kind,
  output logic [1:0]                out_status,
  output logic [31:0]               out_index,
  output logic signed [31:0]        out_value,
  output logic                      out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [IW+31:0] mem_a [DEPTH];
  logic [IW+31:0] mem_b [DEPTH];
  logic [IW+31:0] rd_a_r;
  logic [IW+31:0] rd_b_r;

  logic [1:0]     state_r, state_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic signed [63:0] pa_r, pa_nxt;
  logic signed [63:0] pb_r, pb_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic           both_r, both_nxt;
  logic           hold_vld_r, hold_vld_nxt;
  logic [IW-1:0]  hold_idx_r, hold_idx_nxt;
  logic signed [31:0] hold_val_r, hold_val_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_kind_r, out_kind_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [31:0]    out_index_r, out_index_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic           out_last_r, out_last_nxt;

  logic [IW-1:0]      ra_idx, rb_idx;
  logic signed [31:0] ra_val, rb_val;
  logic               a_ok, b_ok, take_a, take_b, both, use_a, use_b;
  logic signed [63:0] prod_a, prod_b;
  logic signed [64:0] sum;
  logic signed [31:0] sat;

  assign ra_idx = rd_a_r[IW+31:32];
  assign rb_idx = rd_b_r[IW+31:32];
  assign ra_val = rd_a_r[31:0];
  assign rb_val = rd_b_r[31:0];
  assign a_ok   = (i_r < cnt_a);
  assign b_ok   = (j_r < cnt_b);
  assign both   = a_ok && b_ok && (ra_idx == rb_idx);
  assign take_a = a_ok && (!b_ok || (ra_idx < rb_idx));
  assign take_b = b_ok && (!a_ok || (rb_idx < ra_idx));
  assign use_a  = take_a || both;
  assign use_b  = take_b || both;
  assign prod_a = ra_val * scale_self;
  assign prod_b = rb_val * scale_other;
  assign sum    = 65'(pa_r >>> FRAC_BITS) + 65'(pb_r >>> FRAC_BITS);

  always_comb begin
    if (sum > 65'(svsm_pkg::SAT_MAX)) begin
      sat = svsm_pkg::SAT_MAX;
    end else if (sum < 65'(svsm_pkg::SAT_MIN)) begin
      sat = svsm_pkg::SAT_MIN;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= {wr_idx, wr_val};
    end
    if (wr_b) begin
      mem_b[wr_addr] <= {wr_idx, wr_val};
    end
    rd_a_r <= mem_a[i_r[AW-1:0]];
    rd_b_r <= mem_b[j_r[AW-1:0]];
  end

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    idx_nxt        = idx_r;
    both_nxt       = both_r;
    hold_vld_nxt   = hold_vld_r;
    hold_idx_nxt   = hold_idx_r;
    hold_val_nxt   = hold_val_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    pop            = 1'b0;
    run_done       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_cmd.is_run) begin
            i_nxt        = '0;
            j_nxt        = '0;
            hold_vld_nxt = 1'b0;
            state_nxt    = S_RD;
          end else begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = svsm_pkg::KIND_ACK;
            out_status_nxt = q_cmd.status;
            out_index_nxt  = '0;
            out_value_nxt  = '0;
            out_last_nxt   = 1'b1;
          end
        end
      end
      S_RD: begin
        if ((i_r == cnt_a) && (j_r == cnt_b)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = svsm_pkg::STAT_OK;
          out_last_nxt   = 1'b1;
          if (hold_vld_r) begin
            out_kind_nxt  = svsm_pkg::KIND_MERGED;
            out_index_nxt = 32'(hold_idx_r);
            out_value_nxt = hold_val_r;
          end else begin
            out_kind_nxt  = svsm_pkg::KIND_EMPTY;
            out_index_nxt = '0;
            out_value_nxt = '0;
          end
          hold_vld_nxt = 1'b0;
          run_done     = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        pa_nxt    = use_a ? prod_a : '0;
        pb_nxt    = use_b ? prod_b : '0;
        idx_nxt   = use_a ? ra_idx : rb_idx;
        both_nxt  = both;
        i_nxt     = i_r + CW'(use_a);
        j_nxt     = j_r + CW'(use_b);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (!both_r || (sat != '0)) begin
          if (hold_vld_r) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = svsm_pkg::KIND_MERGED;
            out_status_nxt = svsm_pkg::STAT_OK;
            out_index_nxt  = 32'(hold_idx_r);
            out_value_nxt  = hold_val_r;
            out_last_nxt   = 1'b0;
          end
          hold_vld_nxt = 1'b1;
          hold_idx_nxt = idx_r;
          hold_val_nxt = sat;
        end
        state_nxt = S_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    idx_r        <= idx_nxt;
    both_r       <= both_nxt;
    hold_idx_r   <= hold_idx_nxt;
    hold_val_r   <= hold_val_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((i_r <= cnt_a) && (j_r <= cnt_b)))
    else $error("merge walk ran past a store count");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    run_done |=> (out_valid_r && out_last_r))
    else $error("run finished without a final result");

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (run_done && !hold_vld_r) |=> (out_kind_r == svsm_pkg::KIND_EMPTY))
    else $error("run with no merged entry did not give the empty marker");

endmodule

`default_nettype wire

/* hw/rtl/sparse_vector_scaled_merge_add.sv */
// Top level of the sparse vector scaled merge add block.
//
// Loads into store A or B are taken one per cycle while busy is low; each
// gives one acknowledge carrying its status. A run merges both stores by
// index and gives result = scale_self*a + scale_other*b, scales in Q(32-F).F
// and result in the entry values' format, with truncated products and a sum
// saturated to 32 bits. The merge engine reads one entry of each store per
// step, taking each distinct index through the read, multiply and sum states;
// busy stays high from the run item until its last result is out. Results are
// strobed by out_valid for one cycle each and cannot be held off; no result is
// dropped. After reset both stores are empty and the scales are 65536 (1.0 at F = 16).
`default_nettype none

module sparse_vector_scaled_merge_add #(
  parameter int DEPTH      = 32,
  parameter int INDEX_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_cmd,
  input  wire logic [31:0]          in_entry_index,
  input  wire logic signed [31:0]   in_entry_value,
  output logic                      out_valid,
  output logic [1:0]                out_kind,
  output logic [1:0]                out_status,
  output logic [31:0]               out_index,
  output logic signed [31:0]        out_value,
  output logic                      out_last,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int IW = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] scale_self_r, scale_self_nxt;
  logic signed [31:0] scale_other_r, scale_other_nxt;

  logic               q_full;
  logic               q_valid;
  logic               push;
  logic               pop;
  svsm_pkg::cmd_t     push_cmd;
  svsm_pkg::cmd_t     q_head;
  logic               wr_a;
  logic               wr_b;
  logic [AW-1:0]      wr_addr;
  logic [IW-1:0]      wr_idx;
  logic signed [31:0] wr_val;
  logic [CW-1:0]      cnt_a;
  logic [CW-1:0]      cnt_b;
  logic               run_done;

  always_comb begin
    scale_self_nxt  = scale_self_r;
    scale_other_nxt = scale_other_r;
    if (cfg_we) begin
      unique case (cfg_index)
        svsm_pkg::REG_SCALE_SELF:  scale_self_nxt  = cfg_data;
        svsm_pkg::REG_SCALE_OTHER: scale_other_nxt = cfg_data;
        default: begin
          scale_self_nxt = scale_self_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_self_r  <= 32'sd65536;
      scale_other_r <= 32'sd65536;
    end else begin
      scale_self_r  <= scale_self_nxt;
      scale_other_r <= scale_other_nxt;
    end
  end

  svsm_front #(
    .DEPTH(DEPTH),
    .IW   (IW),
    .CW   (CW),
    .AW   (AW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd),
    .wr_a          (wr_a),
    .wr_b          (wr_b),
    .wr_addr       (wr_addr),
    .wr_idx        (wr_idx),
    .wr_val        (wr_val),
    .cnt_a         (cnt_a),
    .cnt_b         (cnt_b),
    .run_done      (run_done)
  );

  svsm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (pop),
    .head    (q_head)
  );

  svsm_merge #(
    .DEPTH    (DEPTH),
    .IW       (IW),
    .CW       (CW),
    .AW       (AW),
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .pop        (pop),
    .wr_a       (wr_a),
    .wr_b       (wr_b),
    .wr_addr    (wr_addr),
    .wr_idx     (wr_idx),
    .wr_val     (wr_val),
    .cnt_a      (cnt_a),
    .cnt_b      (cnt_b),
    .scale_self (scale_self_r),
    .scale_other(scale_other_r),
    .run_done   (run_done),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_status (out_status),
    .out_index  (out_index),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire
